>>> rtl/gb3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb3_pkg: shared types and constants for the 3x3 blur
// Field widths, command and register codes, and the front-to-back op record.
// ----------------------------------------------------------------------------
package gb3_pkg;

   localparam int PIXEL_W      = 8;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 16;
   // one spare bit: the raster position runs up to height + 1 while draining
   localparam int ROW_W        = CFG_HEIGHT_W + 1;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   // 1-2-1 by 1-2-1 over 16: one doubling per axis, divide by 16
   localparam int BLUR_SHIFT   = 4;
   localparam int COLSUM_W     = PIXEL_W + 2;
   localparam int WINSUM_W     = PIXEL_W + BLUR_SHIFT;

   localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = 16'd1024;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } command_type;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [CFG_WIDTH_W-1:0]  width;
      logic [CFG_HEIGHT_W-1:0] height;
      logic                    restart;
   } cfg_type;

   // one column push into the back end
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               up_ok;
      logic               down_ok;
      logic               col_first;
      logic               col_last;
      logic               emit;
      logic               last;
   } op_type;

endpackage
`default_nettype wire

>>> rtl/gb3_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb3_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gb3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/gb3_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb3_front: input classifier
// Tracks the raster position and pending outputs, sorts each beat into
// pixel, drain or no-op, and issues one column push per useful beat.
// ----------------------------------------------------------------------------
module gb3_front import gb3_pkg::*; #(
   parameter int MAX_COLUMNS = 1024,
   localparam int COL_W = $clog2(MAX_COLUMNS)
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [PIXEL_W-1:0] req_tdata,
   input  logic               req_tuser,
   output logic               op_valid,
   input  logic               op_ready,
   output logic [COL_W-1:0]   op_col,
   output op_type             op_flags
);

   localparam int PEND_W = $clog2(MAX_COLUMNS + 2);
   localparam int EXT_W  = ((COL_W + 1) > CFG_WIDTH_W ? (COL_W + 1) : CFG_WIDTH_W) + 1;

   logic [COL_W-1:0]  col_ff,   col_in;
   logic [ROW_W-1:0]  row_ff,   row_in;
   logic [PEND_W-1:0] pend_ff,  pend_in;
   logic              extra_ff, extra_in;

   logic [EXT_W-1:0]  col_ext;
   logic [EXT_W-1:0]  w_ext;
   logic              wrap;
   logic              all_in;
   logic              is_pix;
   logic              is_drain;
   logic              pend_full;
   logic              accept;
   logic              pushed;

   always_comb begin
      col_ext   = EXT_W'(col_ff);
      w_ext     = EXT_W'(cfg.width);
      wrap      = (col_ext + EXT_W'(1)) >= w_ext;
      all_in    = row_ff >= ROW_W'(cfg.height);
      is_pix    = (command_type'(req_tuser) == CMD_PIXEL) && !all_in;
      is_drain  = all_in && (pend_ff != '0);
      pend_full = EXT_W'(pend_ff) == (w_ext + EXT_W'(1));

      // a single-row frame takes one filler push after its last pixel
      req_tready = op_ready && !extra_ff;
      accept     = req_tvalid && req_tready;
      op_valid   = extra_ff || (accept && (is_pix || is_drain));
      pushed     = op_valid && op_ready;

      op_col             = col_ff;
      op_flags.pixel     = req_tdata;
      op_flags.up_ok     = row_ff >= ROW_W'(2);
      op_flags.down_ok   = row_ff < ROW_W'(cfg.height);
      op_flags.col_first = col_ff == '0;
      op_flags.col_last  = wrap;
      op_flags.emit      = !extra_ff && (is_pix ? pend_full : is_drain);
      op_flags.last      = !extra_ff && is_drain && (pend_ff == PEND_W'(1));

      col_in   = col_ff;
      row_in   = row_ff;
      pend_in  = pend_ff;
      extra_in = extra_ff;

      if (pushed) begin
         if (wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = COL_W'(col_ext + EXT_W'(1));
         end
      end

      if (accept && is_pix) begin
         pend_in = pend_full ? pend_ff : pend_ff + PEND_W'(1);
      end else if (accept && is_drain) begin
         pend_in = pend_ff - PEND_W'(1);
      end

      if (extra_ff && op_ready) begin
         extra_in = 1'b0;
      end else if (accept && is_pix && wrap && (cfg.height == CFG_HEIGHT_W'(1))) begin
         extra_in = 1'b1;
      end

      // frame done or register written: start over at the top left
      if ((pushed && op_flags.last) || cfg.restart) begin
         col_in   = '0;
         row_in   = '0;
         pend_in  = '0;
         extra_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= '0;
         extra_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
         extra_ff <= extra_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/gb3_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb3_queue: two-entry op queue
// Decouples the classifier from the line-buffer pipeline.
// ----------------------------------------------------------------------------
module gb3_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      push_ready = count_ff != CNT_W'(DEPTH);
      pop_valid  = count_ff != '0;
      pop_data   = slot_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/gb3_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb3_back: line buffers, window and filter
// Reads the two stored rows at the pushed column, forms the masked vertical
// 1-2-1 sum, shifts it into a three-column window and emits the blurred pixel.
// ----------------------------------------------------------------------------
module gb3_back import gb3_pkg::*; #(
   parameter int MAX_COLUMNS = 1024,
   localparam int COL_W = $clog2(MAX_COLUMNS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               op_valid,
   output logic               op_ready,
   input  logic [COL_W-1:0]   op_col,
   input  op_type             op_flags,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [PIXEL_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   localparam int PAIR_W = 2 * PIXEL_W;

   logic                s1_valid_ff,  s1_valid_in;
   logic                bypass_ff,    bypass_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]    s1_col_ff;
   op_type              s1_op_ff;
   logic [PAIR_W-1:0]   byp_data_ff;
   logic [COLSUM_W-1:0] c1_ff;
   logic [COLSUM_W-1:0] c2_ff;
   logic                c1_first_ff;
   logic                c1_last_ff;
   logic [PIXEL_W-1:0]  rsp_data_ff;
   logic                rsp_last_ff;

   logic                adv;
   logic                process;
   logic [PAIR_W-1:0]   rd_data;
   logic [PAIR_W-1:0]   wr_data;
   logic [PIXEL_W-1:0]  up_px;
   logic [PIXEL_W-1:0]  mid_px;
   logic [COLSUM_W-1:0] colsum;
   logic [COLSUM_W-1:0] left_sum;
   logic [COLSUM_W-1:0] right_sum;
   logic [WINSUM_W-1:0] winsum;

   // upper row in the high byte, middle row in the low byte
   gb3_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (MAX_COLUMNS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (process),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (adv && op_valid),
      .rd_addr (op_col),
      .rd_data (rd_data)
   );

   always_comb begin
      adv      = !rsp_valid_ff || rsp_tready;
      op_ready = adv;
      process  = adv && s1_valid_ff;

      // forward the write still in flight when a one-column image reuses it
      up_px  = bypass_ff ? byp_data_ff[PAIR_W-1:PIXEL_W] : rd_data[PAIR_W-1:PIXEL_W];
      mid_px = bypass_ff ? byp_data_ff[PIXEL_W-1:0]      : rd_data[PIXEL_W-1:0];
      wr_data = {mid_px, s1_op_ff.pixel};

      colsum = COLSUM_W'(s1_op_ff.up_ok ? up_px : '0)
             + {1'b0, mid_px, 1'b0}
             + COLSUM_W'(s1_op_ff.down_ok ? s1_op_ff.pixel : '0);

      left_sum  = c1_first_ff ? '0 : c2_ff;
      right_sum = c1_last_ff  ? '0 : colsum;
      winsum    = WINSUM_W'(left_sum) + WINSUM_W'({c1_ff, 1'b0}) + WINSUM_W'(right_sum);

      s1_valid_in  = adv ? op_valid : s1_valid_ff;
      bypass_in    = adv ? (op_valid && s1_valid_ff && (s1_col_ff == op_col)) : bypass_ff;
      rsp_valid_in = adv ? (s1_valid_ff && s1_op_ff.emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff   <= op_col;
         s1_op_ff    <= op_flags;
         byp_data_ff <= wr_data;
      end
      if (process) begin
         c2_ff       <= c1_ff;
         c1_ff       <= colsum;
         c1_first_ff <= s1_op_ff.col_first;
         c1_last_ff  <= s1_op_ff.col_last;
      end
      if (process && s1_op_ff.emit) begin
         rsp_data_ff <= winsum[WINSUM_W-1:BLUR_SHIFT];
         rsp_last_ff <= s1_op_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

>>> rtl/gaussian_blur_3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_blur_3x3: streaming 3x3 blur, 1-2-1 by 1-2-1 over 16
// Output pixel q is released by input pixel q + width + 1 or by a drain and
//   leaves through the op queue, stage-1 register and output register.
// Throughput: one beat per clock while the output is not stalled, bounded by
//   one line-RAM read and write per beat; one-row frames end on a filler push.
// Reset (synchronous): clears counters, queue and valids; width goes to
//   min(1024, MAX_COLUMNS), height to 1024; the line RAM is not cleared.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3 import gb3_pkg::*; #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,   // [7:0] pixel_in
   input  logic                  req_tuser,   // [0] command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_W-1:0]    rsp_tdata,   // [7:0] pixel_out
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_W = $clog2(MAX_COLUMNS);
   localparam int OP_W  = COL_W + $bits(op_type);
   localparam logic [CFG_WIDTH_W-1:0] RESET_WIDTH =
      CFG_WIDTH_W'((MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024);

   logic [CFG_WIDTH_W-1:0]  width_ff,  width_in;
   logic [CFG_HEIGHT_W-1:0] height_ff, height_in;

   logic                    csr_write;
   csr_reg_type             csr_reg;
   logic [CFG_WIDTH_W-1:0]  wr_width;
   logic [CFG_HEIGHT_W-1:0] wr_height;
   cfg_type                 cfg;

   logic                    push_valid;
   logic                    push_ready;
   logic [COL_W-1:0]        push_col;
   op_type                  push_op;
   logic                    pop_valid;
   logic                    pop_ready;
   logic [OP_W-1:0]         pop_data;

   always_comb begin
      csr_pready = 1'b1;
      csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
      csr_reg    = csr_reg_type'(csr_paddr[2]);

      // clamp width into 1..MAX_COLUMNS, height zero acts as one
      wr_width = csr_pwdata[CFG_WIDTH_W-1:0];
      if (wr_width == '0) begin
         wr_width = CFG_WIDTH_W'(1);
      end else if (32'(wr_width) > 32'(MAX_COLUMNS)) begin
         wr_width = CFG_WIDTH_W'(MAX_COLUMNS);
      end
      wr_height = csr_pwdata[CFG_HEIGHT_W-1:0];
      if (wr_height == '0) begin
         wr_height = CFG_HEIGHT_W'(1);
      end

      width_in  = width_ff;
      height_in = height_ff;
      case (csr_reg)
         REG_IMAGE_WIDTH: begin
            if (csr_write) width_in = wr_width;
            csr_prdata = CSR_DATA_W'(width_ff);
         end
         REG_IMAGE_HEIGHT: begin
            if (csr_write) height_in = wr_height;
            csr_prdata = CSR_DATA_W'(height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase

      cfg.width   = width_ff;
      cfg.height  = height_ff;
      cfg.restart = csr_write;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   gb3_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (push_valid),
      .op_ready   (push_ready),
      .op_col     (push_col),
      .op_flags   (push_op)
   );

   gb3_queue #(
      .WIDTH (OP_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_col, push_op}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   gb3_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (pop_valid),
      .op_ready   (pop_ready),
      .op_col     (pop_data[OP_W-1:$bits(op_type)]),
      .op_flags   (op_type'(pop_data[$bits(op_type)-1:0])),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

>>> rtl/gb3_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gb3_checker: port-level assertions for the blur
// Watches the stream and register ports of the top level over time.
// ----------------------------------------------------------------------------
module gb3_checker import gb3_pkg::*; #(
   parameter int MAX_COLUMNS = 1024
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [PIXEL_W-1:0]    req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [PIXEL_W-1:0]    rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   logic csr_write;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // reset drops any pending result
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_height_readback: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_paddr[2] && (csr_pwdata[CFG_HEIGHT_W-1:0] != '0)
      |=> !csr_paddr[2] ||
          (csr_prdata == CSR_DATA_W'($past(csr_pwdata[CFG_HEIGHT_W-1:0]))))
      else $error("height register readback mismatch");

   a_width_readback: assert property (@(posedge clock) disable iff (reset)
      csr_write && !csr_paddr[2] && (csr_pwdata[CFG_WIDTH_W-1:0] != '0) &&
      (32'(csr_pwdata[CFG_WIDTH_W-1:0]) <= 32'(MAX_COLUMNS))
      |=> csr_paddr[2] ||
          (csr_prdata == CSR_DATA_W'($past(csr_pwdata[CFG_WIDTH_W-1:0]))))
      else $error("width register readback mismatch");

endmodule

bind gaussian_blur_3x3 gb3_checker #(.MAX_COLUMNS(MAX_COLUMNS)) u_checker (.*);
`default_nettype wire

>>> bench/gaussian_blur_3x3_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_tb: self-checking bench for the streaming 3x3 blur
// Writes frame sizes over the register port and streams raster frames and
// drain beats. A copy of each frame predicts every blurred pixel, and each
// result beat is checked in order under several idle and stall mixes.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_tb;
   import gb3_pkg::*;

   localparam int MAX_COLS     = 1024;
   localparam int QUIET_CYCLES = 8;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_BEATS = 950;
   localparam int DEEP_PIXELS  = 1030;

   typedef enum int {ROW_WRITE, ROW_BEAT} row_kind_t;
   typedef enum int {RES_PREDICT, RES_NONE, RES_GIVEN} row_result_t;

   typedef struct {
      row_kind_t           kind;
      csr_reg_type         reg_sel;
      int unsigned         value;
      command_type         cmd;
      logic [PIXEL_W-1:0]  pixel;
      row_result_t         result;
      logic [PIXEL_W-1:0]  out_pixel;
      logic                out_last;
   } directed_row_t;

   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } blurred_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata = '0;     // [7:0] pixel_in
   logic                  req_tuser = 1'b0;   // [0] command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]    rsp_tdata;          // [7:0] pixel_out
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // frame geometry and raster position as the block should see them
   int unsigned        img_w;
   int unsigned        img_h;
   int unsigned        col_pos;
   int unsigned        row_pos;
   int unsigned        in_flight;
   logic [PIXEL_W-1:0] raster_pix [int unsigned];

   blurred_t blur_queue [$];
   int       errors = 0;
   int       useful_beats = 0;
   int       sender_idle_pct = 0;
   int       receiver_stall_pct = 0;
   int       quiet_count = 0;

   directed_row_t directed_rows [22] = '{
      '{ROW_WRITE, REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'h00, RES_NONE,    8'd0,  1'b0},
      '{ROW_WRITE, REG_IMAGE_HEIGHT, 0, CMD_PIXEL, 8'h00, RES_NONE,    8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'hFF, RES_NONE,    8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_DRAIN, 8'hA5, RES_GIVEN,   8'd63, 1'b1},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_DRAIN, 8'hA5, RES_NONE,    8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'h00, RES_NONE,    8'd0,  1'b0},
      // pixel past the frame end behaves as a drain
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'h80, RES_GIVEN,   8'd0,  1'b1},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_DRAIN, 8'h5A, RES_NONE,    8'd0,  1'b0},
      '{ROW_WRITE, REG_IMAGE_WIDTH,  3, CMD_PIXEL, 8'h00, RES_NONE,    8'd0,  1'b0},
      '{ROW_WRITE, REG_IMAGE_HEIGHT, 2, CMD_PIXEL, 8'h00, RES_NONE,    8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'hFF, RES_PREDICT, 8'd0,  1'b0},
      // drain while the frame is still open does nothing
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_DRAIN, 8'hFF, RES_NONE,    8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'h00, RES_PREDICT, 8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'hFF, RES_PREDICT, 8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'h11, RES_PREDICT, 8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'hC8, RES_PREDICT, 8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_PIXEL, 8'h01, RES_PREDICT, 8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_DRAIN, 8'h00, RES_PREDICT, 8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_DRAIN, 8'h00, RES_PREDICT, 8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_DRAIN, 8'h00, RES_PREDICT, 8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_DRAIN, 8'h00, RES_PREDICT, 8'd0,  1'b0},
      '{ROW_BEAT,  REG_IMAGE_WIDTH,  0, CMD_DRAIN, 8'h00, RES_NONE,    8'd0,  1'b0}
   };

   gaussian_blur_3x3 dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void restart_frame();
      col_pos   = 0;
      row_pos   = 0;
      in_flight = 0;
      raster_pix.delete();
   endfunction

   function automatic void set_register(csr_reg_type sel, logic [CSR_DATA_W-1:0] value);
      int unsigned v;
      if (sel == REG_IMAGE_WIDTH) begin
         v = value[CFG_WIDTH_W-1:0];
         if (v == 0) v = 1;
         if (v > MAX_COLS) v = MAX_COLS;
         img_w = v;
      end else begin
         v = value[CFG_HEIGHT_W-1:0];
         img_h = (v == 0) ? 1 : v;
      end
      restart_frame();
   endfunction

   // neighbors outside the frame weigh nothing; no renormalizing
   function automatic logic [PIXEL_W-1:0] blur_pixel(int unsigned q);
      int          orow;
      int          ocol;
      int          r;
      int          c;
      int unsigned sum;
      int unsigned wt;
      orow = q / img_w;
      ocol = q % img_w;
      sum  = 0;
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            r = orow + dy;
            c = ocol + dx;
            if (r >= 0 && c >= 0 && r < int'(img_h) && c < int'(img_w)) begin
               wt  = (dy == 0 ? 2 : 1) * (dx == 0 ? 2 : 1);
               sum += wt * raster_pix[r * img_w + c];
            end
         end
      end
      return PIXEL_W'(sum >> BLUR_SHIFT);
   endfunction

   function automatic bit advance_raster(command_type cmd, logic [PIXEL_W-1:0] pix,
                                         output blurred_t res);
      bit          all_in;
      bit          emit;
      int unsigned received;
      all_in   = row_pos >= img_h;
      received = row_pos * img_w + col_pos;
      emit     = 1'b0;
      res      = '{pixel: '0, last: 1'b0};
      if (cmd == CMD_PIXEL && !all_in) begin
         raster_pix[received] = pix;
         received++;
         col_pos++;
         if (col_pos >= img_w) begin
            col_pos = 0;
            row_pos++;
         end
         in_flight++;
         if (in_flight > img_w + 1) emit = 1'b1;
         all_in = row_pos >= img_h;
      end else if (all_in && in_flight > 0) begin
         emit = 1'b1;
      end
      if (!emit) return 1'b0;
      res.pixel = blur_pixel(received - in_flight);
      in_flight--;
      if (in_flight == 0 && all_in) begin
         res.last = 1'b1;
         restart_frame();
      end
      return 1'b1;
   endfunction

   function automatic logic [PIXEL_W-1:0] random_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom_range(255));
      endcase
   endfunction

   function automatic void set_idle(int phase);
      case (phase % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
         default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
      endcase
   endfunction

   // called just after a falling edge; returns just after one
   task automatic send_beat(command_type cmd, logic [PIXEL_W-1:0] pix,
                            row_result_t mode, blurred_t given);
      blurred_t res;
      bit       has;
      bit       was_open;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      was_open = row_pos < img_h;
      has = advance_raster(cmd, pix, res);
      if (has || (cmd == CMD_PIXEL && was_open)) useful_beats++;
      if (mode == RES_GIVEN) blur_queue.push_back(given);
      else if (mode == RES_PREDICT && has) blur_queue.push_back(res);
      @(negedge clock);
   endtask

   task automatic send_drain();
      blurred_t none;
      none = '{pixel: '0, last: 1'b0};
      send_beat(CMD_DRAIN, random_pixel(), RES_PREDICT, none);
   endtask

   task automatic send_pixel();
      blurred_t none;
      none = '{pixel: '0, last: 1'b0};
      send_beat(CMD_PIXEL, random_pixel(), RES_PREDICT, none);
   endtask

   task automatic write_register(csr_reg_type sel, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(sel));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      set_register(sel, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // hold the input idle until every predicted pixel is back, then let the
   // pipeline empty before touching a register
   task automatic settle();
      req_tvalid <= 1'b0;
      while (blur_queue.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      blurred_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blur_queue.size() == 0) begin
            errors++;
            $display("%0t: result beat with none pending, got pixel %0d last %0b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = blur_queue.pop_front();
            if (rsp_tdata !== want.pixel || rsp_tlast !== want.last) begin
               errors++;
               $display("%0t: result beat expected pixel %0d last %0b, got pixel %0d last %0b",
                        $time, want.pixel, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // count cycles with no beat moving on any port
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_count <= 0;
      end else begin
         quiet_count <= quiet_count + 1;
         if (quiet_count >= STALL_LIMIT) begin
            $display("gaussian_blur_3x3: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int          phase;
      bit          restart_needed;
      bit          broken;
      int unsigned w_val;
      int unsigned h_val;
      int unsigned px_total;
      blurred_t    given;

      img_w = MAX_COLS;
      img_h = RESET_HEIGHT;
      restart_frame();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_idle(0);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle();
            write_register(directed_rows[i].reg_sel, directed_rows[i].value);
         end else begin
            given = '{pixel: directed_rows[i].out_pixel, last: directed_rows[i].out_last};
            send_beat(directed_rows[i].cmd, directed_rows[i].pixel,
                      directed_rows[i].result, given);
         end
      end

      // deep rows: width clamps to the full line buffer, tallest height
      set_idle(1);
      settle();
      write_register(REG_IMAGE_WIDTH, 32'h7FF);
      write_register(REG_IMAGE_HEIGHT, 32'hFFFF);
      for (int i = 0; i < DEEP_PIXELS; i++) begin
         if ($urandom_range(99) < 3) send_drain();
         send_pixel();
      end

      useful_beats   = 0;
      phase          = 0;
      restart_needed = 1'b1;
      while (useful_beats < RANDOM_BEATS) begin
         set_idle(phase);
         if (restart_needed || $urandom_range(99) < 50) begin
            settle();
            case ($urandom_range(9))
               0: w_val = 0;
               1: w_val = 1;
               2: w_val = $urandom_range(9, 40);
               default: w_val = $urandom_range(2, 8);
            endcase
            case ($urandom_range(9))
               0: h_val = 0;
               1: h_val = 1;
               2: h_val = $urandom_range(7, 12);
               default: h_val = $urandom_range(2, 6);
            endcase
            case ($urandom_range(3))
               0: write_register(REG_IMAGE_WIDTH, w_val);
               1: write_register(REG_IMAGE_HEIGHT, h_val);
               2: begin
                  write_register(REG_IMAGE_HEIGHT, h_val);
                  write_register(REG_IMAGE_WIDTH, w_val);
               end
               default: begin
                  write_register(REG_IMAGE_WIDTH, w_val);
                  write_register(REG_IMAGE_HEIGHT, h_val);
               end
            endcase
         end
         px_total = img_w * img_h;
         broken   = $urandom_range(99) < 15;
         restart_needed = broken;
         if (broken) begin
            // cut the frame short; the next register write abandons it
            repeat ($urandom_range(px_total - 1)) begin
               if ($urandom_range(99) < 10) send_drain();
               else send_pixel();
            end
         end else begin
            repeat (px_total) begin
               if ($urandom_range(99) < 8) send_drain();
               send_pixel();
            end
            while (in_flight > 0) begin
               if ($urandom_range(99) < 20) send_pixel();
               else send_drain();
            end
            if ($urandom_range(99) < 10) send_drain();
         end
         phase++;
      end

      settle();
      if (errors == 0) begin
         $display("gaussian_blur_3x3: match");
      end else begin
         $display("gaussian_blur_3x3: mismatch");
      end
      $finish;
   end

endmodule

>>> gaussian_blur_3x3.f
rtl/gb3_pkg.sv
rtl/gb3_ram.sv
rtl/gb3_front.sv
rtl/gb3_queue.sv
rtl/gb3_back.sv
rtl/gaussian_blur_3x3.sv
rtl/gb3_checker.sv
bench/gaussian_blur_3x3_tb.sv
